// File: hw/rtl/acs_pkg.sv
`default_nettype none
package acs_pkg;

   localparam int MEM_WORDS  = 4096;
   localparam int ADDR_W     = $clog2(MEM_WORDS);
   localparam int REQ_ADDR_W = 12;
   localparam int WORD_W     = 16;
   localparam int SP_W       = 13;
   localparam int ACC_W      = 32;

   localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

   // request kinds
   localparam logic [1:0] RQ_WRITE = 2'd0;
   localparam logic [1:0] RQ_EXEC  = 2'd1;
   localparam logic [1:0] RQ_READ  = 2'd2;

   // run status codes
   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_HALT  = 3'd1;
   localparam logic [2:0] ST_PCOOR = 3'd2;
   localparam logic [2:0] ST_SOVF  = 3'd3;
   localparam logic [2:0] ST_SUNF  = 3'd4;
   localparam logic [2:0] ST_BADOP = 3'd5;

   typedef struct packed {
      logic                  full;
      logic [1:0]            kind;
      logic [REQ_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]     wdata;
   } acs_req_type;

   typedef struct packed {
      logic [15:0]       pc;
      logic [SP_W-1:0]   sp;
      logic [ACC_W-1:0]  acc;
      logic              zf;
      logic              outv;
      logic [2:0]        status;
      logic [WORD_W-1:0] rdata;
   } acs_rsp_type;

   typedef struct packed {
      logic take;
      logic fin;
      logic clearing;
   } acs_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/acs_ram.sv
`default_nettype none
module acs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hw/rtl/acs_core.sv
`default_nettype none
module acs_core
   import acs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire acs_req_type req_i,
   input  wire logic        out_free,
   output      acs_ctl_type ctl_o,
   output      acs_rsp_type rsp_o
);

   localparam logic [5:0] OP_NOP   = 6'd0;
   localparam logic [5:0] OP_HALT  = 6'd1;
   localparam logic [5:0] OP_LOAD  = 6'd2;
   localparam logic [5:0] OP_STW   = 6'd3;
   localparam logic [5:0] OP_LDI   = 6'd4;
   localparam logic [5:0] OP_ADD   = 6'd5;
   localparam logic [5:0] OP_ADDI  = 6'd6;
   localparam logic [5:0] OP_SUB   = 6'd7;
   localparam logic [5:0] OP_JMP   = 6'd8;
   localparam logic [5:0] OP_JZ    = 6'd9;
   localparam logic [5:0] OP_JNZ   = 6'd10;
   localparam logic [5:0] OP_PUSH  = 6'd11;
   localparam logic [5:0] OP_POP   = 6'd12;
   localparam logic [5:0] OP_CALL  = 6'd13;
   localparam logic [5:0] OP_RET   = 6'd14;
   localparam logic [5:0] OP_MUL   = 6'd15;
   localparam logic [5:0] OP_OUT   = 6'd16;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_PASS   = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_DECODE = 3'd4;
   localparam logic [2:0] S_EXEC   = 3'd5;
   localparam logic [2:0] S_MULWB  = 3'd6;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);

   function automatic logic [ACC_W-1:0] sext16(input logic [WORD_W-1:0] w);
      return {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
   endfunction

   function automatic logic [ACC_W-1:0] sext10(input logic [9:0] x);
      return {{(ACC_W-10){x[9]}}, x};
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [15:0]       pc_ff, pc_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              zf_ff, zf_in;
   logic [2:0]        st_ff, st_in;
   logic [5:0]        op_ff, op_in;
   logic [ACC_W-1:0]  prod_ff, prod_in;
   logic              pcoor_ff, pcoor_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic              mem_en, mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata, mem_rd;

   logic              done, fin, take, set_z, outv, port_busy;
   logic [WORD_W-1:0] rdata;
   logic [5:0]        dec_op;
   logic [9:0]        dec_opnd;
   logic [15:0]       pc_inc;
   logic [SP_W-1:0]   sp_dec;
   logic [ACC_W-1:0]  m32;
   logic              opnd_ok, sp_ok;

   acs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rd)
   );

   assign dec_op   = mem_rd[15:10];
   assign dec_opnd = mem_rd[9:0];
   assign pc_inc   = pc_ff + 16'd1;
   assign sp_dec   = sp_ff - SP_W'(1);
   assign m32      = sext16(mem_rd);
   assign opnd_ok  = 17'(dec_opnd) < MEM_LIMIT;
   assign sp_ok    = 17'(sp_ff) < MEM_LIMIT;

   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      sp_in       = sp_ff;
      acc_in      = acc_ff;
      zf_in       = zf_ff;
      st_in       = st_ff;
      op_in       = op_ff;
      prod_in     = prod_ff;
      pcoor_in    = pcoor_ff;
      clr_addr_in = clr_addr_ff;
      mem_en      = 1'b0;
      mem_we      = 1'b0;
      mem_addr    = '0;
      mem_wdata   = '0;
      done        = 1'b0;
      set_z       = 1'b0;
      outv        = 1'b0;
      rdata       = '0;
      take        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_en      = 1'b1;
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
         end
         S_PASS: begin
            done = 1'b1;
            if (pcoor_ff) begin
               st_in = ST_PCOOR;
            end
         end
         S_RDWAIT: begin
            done  = 1'b1;
            rdata = mem_rd;
         end
         S_DECODE: begin
            pc_in = pc_inc;
            unique case (dec_op)
               OP_LOAD, OP_ADD, OP_SUB, OP_MUL: begin
                  if (opnd_ok) begin
                     mem_en   = 1'b1;
                     mem_addr = ADDR_W'(dec_opnd);
                     op_in    = dec_op;
                     state_in = S_EXEC;
                  end else begin
                     done  = 1'b1;
                     st_in = ST_BADOP;
                  end
               end
               OP_STW: begin
                  done = 1'b1;
                  if (opnd_ok) begin
                     mem_en    = 1'b1;
                     mem_we    = 1'b1;
                     mem_addr  = ADDR_W'(dec_opnd);
                     mem_wdata = acc_ff[WORD_W-1:0];
                     set_z     = 1'b1;
                  end else begin
                     st_in = ST_BADOP;
                  end
               end
               OP_NOP: begin
                  done = 1'b1;
               end
               OP_HALT: begin
                  done  = 1'b1;
                  st_in = ST_HALT;
               end
               OP_LDI: begin
                  done   = 1'b1;
                  acc_in = sext10(dec_opnd);
                  set_z  = 1'b1;
               end
               OP_ADDI: begin
                  done   = 1'b1;
                  acc_in = acc_ff + sext10(dec_opnd);
                  set_z  = 1'b1;
               end
               OP_JMP: begin
                  done  = 1'b1;
                  pc_in = 16'(dec_opnd);
               end
               OP_JZ: begin
                  done = 1'b1;
                  if (zf_ff) begin
                     pc_in = 16'(dec_opnd);
                  end
               end
               OP_JNZ: begin
                  done = 1'b1;
                  if (!zf_ff) begin
                     pc_in = 16'(dec_opnd);
                  end
               end
               OP_PUSH, OP_CALL: begin
                  done = 1'b1;
                  if (sp_ff == '0) begin
                     st_in = ST_SOVF;
                  end else begin
                     mem_en   = 1'b1;
                     mem_we   = 1'b1;
                     mem_addr = ADDR_W'(sp_dec);
                     sp_in    = sp_dec;
                     if (dec_op == OP_CALL) begin
                        mem_wdata = pc_inc;
                        pc_in     = 16'(dec_opnd);
                     end else begin
                        mem_wdata = acc_ff[WORD_W-1:0];
                     end
                  end
               end
               OP_POP, OP_RET: begin
                  if (sp_ok) begin
                     mem_en   = 1'b1;
                     mem_addr = ADDR_W'(sp_ff);
                     op_in    = dec_op;
                     state_in = S_EXEC;
                  end else begin
                     done  = 1'b1;
                     st_in = ST_SUNF;
                  end
               end
               OP_OUT: begin
                  done = 1'b1;
                  outv = 1'b1;
               end
               default: begin
                  done  = 1'b1;
                  st_in = ST_BADOP;
               end
            endcase
         end
         S_EXEC: begin
            pc_in = pc_inc;
            unique case (op_ff)
               OP_LOAD: begin
                  done   = 1'b1;
                  acc_in = m32;
                  set_z  = 1'b1;
               end
               OP_ADD: begin
                  done   = 1'b1;
                  acc_in = acc_ff + m32;
                  set_z  = 1'b1;
               end
               OP_SUB: begin
                  done   = 1'b1;
                  acc_in = acc_ff - m32;
                  set_z  = 1'b1;
               end
               OP_POP: begin
                  done   = 1'b1;
                  acc_in = m32;
                  sp_in  = sp_ff + SP_W'(1);
                  set_z  = 1'b1;
               end
               OP_RET: begin
                  done  = 1'b1;
                  pc_in = mem_rd;
                  sp_in = sp_ff + SP_W'(1);
               end
               OP_MUL: begin
                  prod_in  = acc_ff * m32;
                  state_in = S_MULWB;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_MULWB: begin
            done   = 1'b1;
            pc_in  = pc_inc;
            acc_in = prod_ff;
            set_z  = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (set_z) begin
         zf_in = (acc_in == '0);
      end

      fin = done && out_free;
      if (done) begin
         state_in = fin ? S_IDLE : state_ff;
      end

      // next item may start in the finishing cycle when the port is free
      port_busy = mem_en;
      if (req_i.full && ((state_ff == S_IDLE) || (fin && !port_busy))) begin
         take     = 1'b1;
         pcoor_in = 1'b0;
         state_in = S_PASS;
         unique case (req_i.kind)
            RQ_WRITE: begin
               if (17'(req_i.addr) < MEM_LIMIT) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = ADDR_W'(req_i.addr);
                  mem_wdata = req_i.wdata;
               end
            end
            RQ_READ: begin
               if (17'(req_i.addr) < MEM_LIMIT) begin
                  mem_en   = 1'b1;
                  mem_addr = ADDR_W'(req_i.addr);
                  state_in = S_RDWAIT;
               end
            end
            RQ_EXEC: begin
               if (st_in == ST_RUN) begin
                  if (17'(pc_in) < MEM_LIMIT) begin
                     mem_en   = 1'b1;
                     mem_addr = ADDR_W'(pc_in);
                     state_in = S_DECODE;
                  end else begin
                     pcoor_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         pcoor_ff    <= 1'b0;
         pc_ff       <= '0;
         sp_ff       <= SP_W'(MEM_WORDS);
         acc_ff      <= '0;
         zf_ff       <= 1'b0;
         st_ff       <= ST_RUN;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         pcoor_ff    <= pcoor_in;
         if (fin) begin
            pc_ff  <= pc_in;
            sp_ff  <= sp_in;
            acc_ff <= acc_in;
            zf_ff  <= zf_in;
            st_ff  <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      prod_ff <= prod_in;
   end

   assign ctl_o.take     = take;
   assign ctl_o.fin      = fin;
   assign ctl_o.clearing = (state_ff == S_CLEAR);

   assign rsp_o.pc     = pc_in;
   assign rsp_o.sp     = sp_in;
   assign rsp_o.acc    = acc_in;
   assign rsp_o.zf     = zf_in;
   assign rsp_o.outv   = outv;
   assign rsp_o.status = st_in;
   assign rsp_o.rdata  = rdata;

endmodule
`default_nettype wire

// File: hw/rtl/accumulator_cpu_step.sv
// Accumulator processor with one shared 4096 x 16 program, data and stack memory.
// Input channel (req_valid / req_stall): req_type selects write word, execute one
// instruction or read word; req_address and req_write_data serve the memory items.
// Result channel (rsp_valid / rsp_stall): one result per item with pc, sp,
// accumulator, zero flag, output strobe, run status and read data.
// An accepted item waits in a one-entry request register and starts as soon as
// the sequencer can use the memory port; a result waits in an output register.
// From acceptance an item passes the request register, then a PASS, RDWAIT or
// DECODE state and the output register; load, add, sub, pop and ret add an
// EXEC state, mul an EXEC and a MULWB state.
// A new item may start in the finishing cycle of the last one unless that
// cycle uses the single memory port; a store, push or call holds the port in
// its last cycle, so the next item waits.
// After reset the memory is swept to zero, one word a cycle through all 4096
// words with req_stall high. While rsp_stall is high the finished result is held,
// one more item is accepted, and processing stops at the next result.
`default_nettype none
module accumulator_cpu_step
   import acs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [1:0]               req_type,
   input  wire logic [REQ_ADDR_W-1:0]    req_address,
   input  wire logic [WORD_W-1:0]        req_write_data,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [15:0]              rsp_program_counter,
   output      logic [SP_W-1:0]          rsp_stack_pointer,
   output      logic signed [ACC_W-1:0]  rsp_accumulator,
   output      logic                     rsp_zero_flag,
   output      logic                     rsp_out_valid,
   output      logic [2:0]               rsp_run_status,
   output      logic [WORD_W-1:0]        rsp_read_data
);

   acs_req_type req_ff, req_in;
   acs_rsp_type rsp_ff, rsp_res;
   acs_ctl_type ctl;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept, out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = ctl.clearing || (req_ff.full && !ctl.take);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_in      = req_ff;
      req_in.full = accept || (req_ff.full && !ctl.take);
      if (accept) begin
         req_in.kind  = req_type;
         req_in.addr  = req_address;
         req_in.wdata = req_write_data;
      end
   end

   assign rsp_valid_in = ctl.fin || (rsp_valid_ff && rsp_stall);

   acs_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req_i    (req_ff),
      .out_free (out_free),
      .ctl_o    (ctl),
      .rsp_o    (rsp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.full  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_ff.full  <= req_in.full;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff.kind  <= req_in.kind;
      req_ff.addr  <= req_in.addr;
      req_ff.wdata <= req_in.wdata;
      if (ctl.fin) begin
         rsp_ff <= rsp_res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_program_counter = rsp_ff.pc;
   assign rsp_stack_pointer   = rsp_ff.sp;
   assign rsp_accumulator     = $signed(rsp_ff.acc);
   assign rsp_zero_flag       = rsp_ff.zf;
   assign rsp_out_valid       = rsp_ff.outv;
   assign rsp_run_status      = rsp_ff.status;
   assign rsp_read_data       = rsp_ff.rdata;

endmodule
`default_nettype wire
